FILE: rtl/cfr_pkg.sv
// Shared definitions for the CRC-8 command frame receiver.
// Holds the command word between the front and back ends, the configuration
// bundle and register reset values. No dependencies.
package cfr_pkg;

   localparam int TIMEOUT_W = 16;
   localparam int PULSE_W   = 11;
   localparam int PATTERN_W = 4;

   // Command codes handed from the frame assembler to the executor
   localparam logic [1:0] EV_NONE     = 2'd0;
   localparam logic [1:0] EV_TICK     = 2'd1;
   localparam logic [1:0] EV_CRC_FAIL = 2'd2;
   localparam logic [1:0] EV_APPLY    = 2'd3;

   // Register indexes on the csr channel
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] REG_TIMEOUT  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_NEUTRAL  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_FULL_FWD = 2'd2;
   localparam int CSR_DATA_W = 16;

   localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET  = 16'd300;
   localparam logic [PULSE_W-1:0]   NEUTRAL_RESET  = 11'd1500;
   localparam logic [PULSE_W-1:0]   FULL_FWD_RESET = 11'd1350;

   localparam int QUEUE_DEPTH = 2;

   typedef struct packed {
      logic [TIMEOUT_W-1:0] timeout_ms;
      logic [PULSE_W-1:0]   neutral_pulse_us;
      logic [PULSE_W-1:0]   full_forward_pulse_us;
   } cfg_type;

   // quot is round(range * duty / 255), already worked out by the front end
   typedef struct packed {
      logic [1:0]           ev;
      logic [PATTERN_W-1:0] pattern;
      logic [PULSE_W-1:0]   quot;
   } cmd_type;

endpackage

FILE: rtl/cfr_if.sv
// Channel interfaces for the CRC-8 command frame receiver: input items,
// result items and register writes, each with valid/ready.
// Depends on cfr_pkg.
interface cfr_req_if;
   logic       valid;
   logic       ready;
   logic       kind;
   logic [7:0] rx_byte;

   modport source (output valid, output kind, output rx_byte, input ready);
   modport sink (input valid, input kind, input rx_byte, output ready);
endinterface

interface cfr_rsp_if;
   logic                           valid;
   logic                           ready;
   logic                           frame_accepted;
   logic                           crc_failed;
   logic [cfr_pkg::PATTERN_W-1:0]  pattern;
   logic [cfr_pkg::PULSE_W-1:0]    motor_pulse_us;
   logic                           link_healthy;
   logic                           render_request;
   logic                           timed_out;

   modport source (output valid, output frame_accepted, output crc_failed,
                   output pattern, output motor_pulse_us, output link_healthy,
                   output render_request, output timed_out, input ready);
   modport sink (input valid, input frame_accepted, input crc_failed,
                 input pattern, input motor_pulse_us, input link_healthy,
                 input render_request, input timed_out, output ready);
endinterface

interface cfr_csr_if;
   logic                            valid;
   logic                            ready;
   logic [cfr_pkg::CSR_IDX_W-1:0]   index;
   logic [cfr_pkg::CSR_DATA_W-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

FILE: rtl/crc8_command_frame_receiver.sv
// Framed command receiver: takes serial bytes and millisecond ticks, one
// item per clock while the result channel is not stalled, and returns one
// result per item (front end into the command queue, back end into the output
// register). Frames are A5 5A, control, pattern, duty, CRC-8 (poly 07, init
// 00); a good frame sets pattern, motor pulse and link health, and ticks age
// the link until it falls back to pattern 0 and the neutral pulse. The
// result after a byte or tick reflects the state once it is applied. Register
// writes are taken at any time but only change behaviour safely while idle.
// Depends on cfr_pkg, cfr_if, cfr_front, cfr_queue and cfr_back.
module crc8_command_frame_receiver #(
   parameter int QUEUE_DEPTH = cfr_pkg::QUEUE_DEPTH
) (
   input  logic      clock,
   input  logic      reset,
   cfr_req_if.sink   req,
   cfr_rsp_if.source rsp,
   cfr_csr_if.sink   csr
);

   cfr_pkg::cfg_type cfg_ff;
   cfr_pkg::cmd_type push_data, pop_data;
   logic push_valid, push_ready, pop_valid, pop_ready;

   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.timeout_ms            <= cfr_pkg::TIMEOUT_RESET;
         cfg_ff.neutral_pulse_us      <= cfr_pkg::NEUTRAL_RESET;
         cfg_ff.full_forward_pulse_us <= cfr_pkg::FULL_FWD_RESET;
      end else if (csr.valid) begin
         case (csr.index)
            cfr_pkg::REG_TIMEOUT:
               cfg_ff.timeout_ms <= csr.data;
            cfr_pkg::REG_NEUTRAL:
               cfg_ff.neutral_pulse_us <= csr.data[cfr_pkg::PULSE_W-1:0];
            cfr_pkg::REG_FULL_FWD:
               cfg_ff.full_forward_pulse_us <= csr.data[cfr_pkg::PULSE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   cfr_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req        (req),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   cfr_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   cfr_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_data  (pop_data),
      .rsp       (rsp)
   );

endmodule

FILE: rtl/cfr_front.sv
// Front end: hunts for sync, assembles the frame, runs the CRC-8 and
// turns each accepted item into a command word. Depends on cfr_pkg.
module cfr_front (
   input  logic              clock,
   input  logic              reset,
   input  cfr_pkg::cfg_type  cfg,
   cfr_req_if.sink           req,
   output logic              push_valid,
   input  logic              push_ready,
   output cfr_pkg::cmd_type  push_data
);

   localparam logic [2:0] S_HUNT  = 3'd0;
   localparam logic [2:0] S_SYNC1 = 3'd1;
   localparam logic [2:0] S_CTRL  = 3'd2;
   localparam logic [2:0] S_PAT   = 3'd3;
   localparam logic [2:0] S_DUTY  = 3'd4;
   localparam logic [2:0] S_CRC   = 3'd5;

   localparam logic [7:0] SYNC_A   = 8'hA5;
   localparam logic [7:0] SYNC_B   = 8'h5A;
   localparam logic [3:0] CTRL_VER = 4'hA;
   localparam logic [7:0] CRC_POLY = 8'h07;
   localparam logic [7:0] PAT_MAX  = 8'd9;
   localparam logic [8:0] DIV_LIM  = 9'd255;
   localparam logic [19:0] ROUND   = 20'd127;

   function automatic logic [7:0] crc8 (input logic [7:0] crc, input logic [7:0] b);
      logic [7:0] c;
      c = crc ^ b;
      for (int i = 0; i < 8; i++) begin
         c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
      end
      return c;
   endfunction

   logic [2:0]  state_ff, state_in;
   logic [7:0]  crc_ff, crc_in;
   logic        ctrl_ok_ff, ctrl_ok_in;
   logic        duty_en_ff, duty_en_in;
   logic        pat_ok_ff, pat_ok_in;
   logic [cfr_pkg::PATTERN_W-1:0] pat_ff, pat_in;
   logic [18:0] prod_ff, prod_in;

   logic        accept;
   logic [7:0]  b;
   logic [cfr_pkg::PULSE_W-1:0] range;
   logic [19:0] x;
   logic [11:0] q0;
   logic [12:0] r0;
   logic [4:0]  q1;
   logic [8:0]  r1;
   logic [11:0] qsum;

   assign req.ready  = push_ready;
   assign push_valid = req.valid;
   assign accept     = req.valid && push_ready;
   assign b          = req.rx_byte;

   assign range = (cfg.full_forward_pulse_us <= cfg.neutral_pulse_us) ?
                  (cfg.neutral_pulse_us - cfg.full_forward_pulse_us) : '0;

   // (prod + 127) / 255 by folding the high byte back in twice
   assign x    = {1'b0, prod_ff} + ROUND;
   assign q0   = x[19:8];
   assign r0   = {5'd0, x[7:0]} + {1'b0, q0};
   assign q1   = r0[12:8];
   assign r1   = {1'b0, r0[7:0]} + {4'd0, q1};
   assign qsum = q0 + {7'd0, q1} + {11'd0, (r1 >= DIV_LIM)};

   always_comb begin
      state_in   = state_ff;
      crc_in     = crc_ff;
      ctrl_ok_in = ctrl_ok_ff;
      duty_en_in = duty_en_ff;
      pat_ok_in  = pat_ok_ff;
      pat_in     = pat_ff;
      prod_in    = prod_ff;
      push_data.ev      = req.kind ? cfr_pkg::EV_TICK : cfr_pkg::EV_NONE;
      push_data.pattern = pat_ff;
      push_data.quot    = qsum[cfr_pkg::PULSE_W-1:0];
      if (!req.kind) begin
         case (state_ff)
            S_HUNT: begin
               if (b == SYNC_A) begin
                  crc_in   = crc8(8'd0, b);
                  state_in = S_SYNC1;
               end
            end
            S_SYNC1: begin
               if (b == SYNC_B) begin
                  crc_in   = crc8(crc_ff, b);
                  state_in = S_CTRL;
               end else if (b == SYNC_A) begin
                  crc_in = crc8(8'd0, b);
               end else begin
                  state_in = S_HUNT;
               end
            end
            S_CTRL: begin
               ctrl_ok_in = (b[7:4] == CTRL_VER) && (b[3:1] == 3'd0);
               duty_en_in = b[0];
               crc_in     = crc8(crc_ff, b);
               state_in   = S_PAT;
            end
            S_PAT: begin
               pat_ok_in = (b <= PAT_MAX);
               pat_in    = b[cfr_pkg::PATTERN_W-1:0];
               crc_in    = crc8(crc_ff, b);
               state_in  = S_DUTY;
            end
            S_DUTY: begin
               prod_in  = 19'(range) * 19'(duty_en_ff ? b : 8'd0);
               crc_in   = crc8(crc_ff, b);
               state_in = S_CRC;
            end
            S_CRC: begin
               state_in = S_HUNT;
               if (b != crc_ff)
                  push_data.ev = cfr_pkg::EV_CRC_FAIL;
               else if (ctrl_ok_ff && pat_ok_ff)
                  push_data.ev = cfr_pkg::EV_APPLY;
            end
            default: begin
               state_in = S_HUNT;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_HUNT;
         crc_ff   <= '0;
      end else if (accept) begin
         state_ff <= state_in;
         crc_ff   <= crc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         ctrl_ok_ff <= ctrl_ok_in;
         duty_en_ff <= duty_en_in;
         pat_ok_ff  <= pat_ok_in;
         pat_ff     <= pat_in;
         prod_ff    <= prod_in;
      end
   end

endmodule

FILE: rtl/cfr_queue.sv
// Small first-word-fall-through queue of command words between the front
// and back ends. Depends on cfr_pkg.
module cfr_queue #(
   parameter int DEPTH = cfr_pkg::QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  cfr_pkg::cmd_type  push_data,
   output logic              pop_valid,
   input  logic              pop_ready,
   output cfr_pkg::cmd_type  pop_data
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
   localparam logic [CW-1:0] FULL = CW'(DEPTH);

   cfr_pkg::cmd_type mem [DEPTH];
   logic [AW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CW-1:0] count_ff;
   logic push, pop;

   assign push_ready = (count_ff != FULL);
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = mem[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_ff @(posedge clock) begin
      if (push)
         mem[wr_ptr_ff] <= push_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push)
            wr_ptr_ff <= (wr_ptr_ff == LAST) ? '0 : wr_ptr_ff + 1'b1;
         if (pop)
            rd_ptr_ff <= (rd_ptr_ff == LAST) ? '0 : rd_ptr_ff + 1'b1;
         if (push && !pop)
            count_ff <= count_ff + 1'b1;
         else if (pop && !push)
            count_ff <= count_ff - 1'b1;
      end
   end

endmodule

FILE: rtl/cfr_back.sv
// Back end: applies command words to the link state (pattern, pulse,
// health, age) and drives the registered result channel. Depends on cfr_pkg.
module cfr_back (
   input  logic              clock,
   input  logic              reset,
   input  cfr_pkg::cfg_type  cfg,
   input  logic              pop_valid,
   output logic              pop_ready,
   input  cfr_pkg::cmd_type  pop_data,
   cfr_rsp_if.source         rsp
);

   localparam logic [cfr_pkg::PULSE_W-1:0]   PULSE_MIN = 11'd1000;
   localparam logic [cfr_pkg::PULSE_W-1:0]   PULSE_MAX = 11'd2000;
   localparam logic [cfr_pkg::TIMEOUT_W-1:0] AGE_MAX   = '1;
   localparam logic [cfr_pkg::PATTERN_W-1:0] ANIM_LO   = 4'd3;
   localparam logic [cfr_pkg::PATTERN_W-1:0] ANIM_HI   = 4'd6;

   function automatic logic [cfr_pkg::PULSE_W-1:0] clamp_pulse (
      input logic [cfr_pkg::PULSE_W-1:0] p);
      if (p < PULSE_MIN)
         return PULSE_MIN;
      else if (p > PULSE_MAX)
         return PULSE_MAX;
      return p;
   endfunction

   logic [cfr_pkg::PATTERN_W-1:0] pat_ff, pat_in;
   logic [cfr_pkg::PULSE_W-1:0]   pulse_ff, pulse_in;
   logic                          healthy_ff, healthy_in;
   logic [cfr_pkg::TIMEOUT_W-1:0] age_ff, age_in;
   logic                          valid_ff;
   logic                          acc_ff, acc_in;
   logic                          fail_ff, fail_in;
   logic                          render_ff, render_in;
   logic                          tout_ff, tout_in;
   logic                          pop;
   logic [cfr_pkg::TIMEOUT_W-1:0] age_next;

   assign pop_ready = !valid_ff || rsp.ready;
   assign pop       = pop_valid && pop_ready;
   assign age_next  = (age_ff == AGE_MAX) ? age_ff : age_ff + 1'b1;

   always_comb begin
      pat_in     = pat_ff;
      pulse_in   = pulse_ff;
      healthy_in = healthy_ff;
      age_in     = age_ff;
      acc_in     = 1'b0;
      fail_in    = 1'b0;
      render_in  = 1'b0;
      tout_in    = 1'b0;
      case (pop_data.ev)
         cfr_pkg::EV_TICK: begin
            if (healthy_ff) begin
               age_in = age_next;
               if (age_next >= cfg.timeout_ms) begin
                  healthy_in = 1'b0;
                  pat_in     = '0;
                  pulse_in   = clamp_pulse(cfg.neutral_pulse_us);
                  render_in  = 1'b1;
                  tout_in    = 1'b1;
               end
            end
         end
         cfr_pkg::EV_CRC_FAIL: begin
            fail_in = 1'b1;
         end
         cfr_pkg::EV_APPLY: begin
            pat_in     = pop_data.pattern;
            // quot never exceeds neutral - full_forward while cfg is unchanged, so no wrap here
            pulse_in   = clamp_pulse(cfg.neutral_pulse_us - pop_data.quot);
            age_in     = '0;
            healthy_in = 1'b1;
            acc_in     = 1'b1;
            render_in  = (pop_data.pattern != pat_ff) ||
                         ((pop_data.pattern >= ANIM_LO) && (pop_data.pattern <= ANIM_HI));
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pat_ff     <= '0;
         pulse_ff   <= cfr_pkg::NEUTRAL_RESET;
         healthy_ff <= 1'b0;
         age_ff     <= '0;
         valid_ff   <= 1'b0;
      end else begin
         if (pop) begin
            pat_ff     <= pat_in;
            pulse_ff   <= pulse_in;
            healthy_ff <= healthy_in;
            age_ff     <= age_in;
         end
         if (pop_ready)
            valid_ff <= pop_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         acc_ff    <= acc_in;
         fail_ff   <= fail_in;
         render_ff <= render_in;
         tout_ff   <= tout_in;
      end
   end

   assign rsp.valid          = valid_ff;
   assign rsp.frame_accepted = acc_ff;
   assign rsp.crc_failed     = fail_ff;
   assign rsp.pattern        = pat_ff;
   assign rsp.motor_pulse_us = pulse_ff;
   assign rsp.link_healthy   = healthy_ff;
   assign rsp.render_request = render_ff;
   assign rsp.timed_out      = tout_ff;

endmodule
